@@ hdl/kdf_pkg.sv @@
// kdf_pkg: shared types, codes and constants of the key debounce event FIFO.
// No dependencies; every other file of the block but kdf_ram imports it.

package kdf_pkg;

	// Block geometry
	localparam int NUM_KEYS       = 2;
	localparam int EVT_PER_KEY    = 2;
	localparam int NUM_SLOTS      = NUM_KEYS * EVT_PER_KEY;
	localparam int BANK_W         = 2;
	localparam int NUM_BANKS      = 2 ** BANK_W;
	localparam int FIFO_DEPTH_DEF = 16;

	// Field widths
	localparam int ACT_W   = 2;
	localparam int CODE_W  = 3;
	localparam int FILT_W  = 7;
	localparam int DEB_W   = 8;
	localparam int HOLD_W  = 16;
	localparam int RPT_W   = 8;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	// Reset values of the registers
	localparam logic [FILT_W-1:0] FILTER_RST = 7'd5;
	localparam logic [HOLD_W-1:0] LONG_RST   = 16'd100;
	localparam logic [RPT_W-1:0]  RPT_RST    = 8'd0;
	localparam logic [DEB_W-1:0]  DEB_RST    = DEB_W'(FILTER_RST / 2);

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_FILTER = 3'd0,
		CFG_LONG0  = 3'd1,
		CFG_LONG1  = 3'd2,
		CFG_RPT0   = 3'd3,
		CFG_RPT1   = 3'd4
	} cfg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		CODE_NONE    = 3'd0,
		CODE_K0_DOWN = 3'd1,
		CODE_K0_UP   = 3'd2,
		CODE_K0_LONG = 3'd3,
		CODE_K1_DOWN = 3'd4,
		CODE_K1_UP   = 3'd5,
		CODE_K1_LONG = 3'd6
	} key_code_t;

	// Events one key raises on one tick; down/up go before long/repeat
	typedef struct packed {
		logic down;
		logic up;
		logic long_press;
		logic rpt;
	} key_evt_t;

	// Item control into the event FIFO, qualified by the input handshake
	typedef struct packed {
		logic tick;
		logic pop;
		logic clear;
	} fifo_ctl_t;

	// What the FIFO did with the current item
	typedef struct packed {
		logic popped;
		logic dropped;
	} fifo_sts_t;

	function automatic key_code_t code_down(input logic key);
		return key ? CODE_K1_DOWN : CODE_K0_DOWN;
	endfunction

	function automatic key_code_t code_up(input logic key);
		return key ? CODE_K1_UP : CODE_K0_UP;
	endfunction

	function automatic key_code_t code_long(input logic key);
		return key ? CODE_K1_LONG : CODE_K0_LONG;
	endfunction

endpackage

@@ hdl/kdf_req_if.sv @@
// kdf_req_if: input item channel (action, raw key levels).
// Depends on kdf_pkg for field widths.

interface kdf_req_if;
	import kdf_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [NUM_KEYS-1:0] key_down;

	modport source (output valid, output action, output key_down, input ready);
	modport sink   (input valid, input action, input key_down, output ready);
endinterface

@@ hdl/kdf_rsp_if.sv @@
// kdf_rsp_if: result channel (popped code, debounced state, drop flag).
// Depends on kdf_pkg for field widths.

interface kdf_rsp_if;
	import kdf_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   key_code;
	logic [NUM_KEYS-1:0] key_state;
	logic                event_dropped;

	modport source (output valid, output key_code, output key_state, output event_dropped,
		input ready);
	modport sink   (input valid, input key_code, input key_state, input event_dropped,
		output ready);
endinterface

@@ hdl/kdf_cfg_if.sv @@
// kdf_cfg_if: register write channel (index, data).
// Depends on kdf_pkg for field widths.

interface kdf_cfg_if;
	import kdf_pkg::*;

	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/kdf_ram.sv @@
// kdf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module kdf_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hdl/kdf_key_lane.sv @@
// kdf_key_lane: debounce, long-press and auto-repeat for one key.
// Depends on kdf_pkg; one instance per key, merged by kdf_event_fifo.

module kdf_key_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      raw_down,
	input  logic [kdf_pkg::FILT_W-1:0] filter_time,
	input  logic [kdf_pkg::HOLD_W-1:0] long_time,
	input  logic [kdf_pkg::RPT_W-1:0]  repeat_speed,
	input  logic                      rpt_clr,
	output kdf_pkg::key_evt_t          evt,
	output logic                      pressed_nxt
);
	import kdf_pkg::*;

	logic [DEB_W-1:0]  deb_q, deb_d;
	logic              pressed_q, pressed_d;
	logic [HOLD_W-1:0] hold_q, hold_d, hold_inc;
	logic [RPT_W-1:0]  rpt_q, rpt_d, rpt_inc;
	logic [DEB_W-1:0]  filt, top;

	assign filt     = {1'b0, filter_time};
	assign top      = {filter_time, 1'b0};
	assign hold_inc = hold_q + 16'd1;
	assign rpt_inc  = rpt_q + 8'd1;

	// integrating counter and hold/repeat tracking for one tick
	always_comb begin
		deb_d     = deb_q;
		pressed_d = pressed_q;
		hold_d    = hold_q;
		rpt_d     = rpt_q;
		evt       = '0;
		if (tick) begin
			if (raw_down) begin
				if (deb_q < filt) begin
					deb_d = filt;
				end else if (deb_q < top) begin
					deb_d = deb_q + 8'd1;
				end else begin
					if (!pressed_q) begin
						pressed_d = 1'b1;
						evt.down  = 1'b1;
					end
					if (long_time != '0) begin
						if (hold_q < long_time) begin
							hold_d = hold_inc;
							evt.long_press = (hold_inc == long_time);
						end else if (repeat_speed != '0) begin
							if (rpt_inc >= repeat_speed) begin
								rpt_d   = '0;
								evt.rpt = 1'b1;
							end else begin
								rpt_d = rpt_inc;
							end
						end
					end
				end
			end else begin
				if (deb_q > filt) begin
					deb_d = filt;
				end else if (deb_q != '0) begin
					deb_d = deb_q - 8'd1;
				end else if (pressed_q) begin
					pressed_d = 1'b0;
					evt.up    = 1'b1;
				end
				hold_d = '0;
				rpt_d  = '0;
			end
		end
		if (rpt_clr) begin
			rpt_d = '0;
		end
	end

	assign pressed_nxt = pressed_d;

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q     <= DEB_RST;
			pressed_q <= 1'b0;
			hold_q    <= '0;
			rpt_q     <= '0;
		end else begin
			deb_q     <= deb_d;
			pressed_q <= pressed_d;
			hold_q    <= hold_d;
			rpt_q     <= rpt_d;
		end
	end
endmodule

@@ hdl/kdf_event_fifo.sv @@
// kdf_event_fifo: merges the lane events into a banked ring FIFO and pops codes.
// Depends on kdf_pkg and kdf_ram.

module kdf_event_fifo #(
	parameter int FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kdf_pkg::fifo_ctl_t         ctl,
	input  kdf_pkg::key_evt_t          evt [kdf_pkg::NUM_KEYS],
	output kdf_pkg::fifo_sts_t         sts,
	output logic [kdf_pkg::CODE_W-1:0] pop_code
);
	import kdf_pkg::*;

	// storage is split into banks so that the pushes of one tick hit distinct banks
	localparam int ROWS_MIN = (FIFO_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
	localparam int ROW_W    = (ROWS_MIN > 1) ? $clog2(ROWS_MIN) : 1;
	localparam int ROWS     = 2 ** ROW_W;
	localparam int PTR_W    = ROW_W + BANK_W;
	localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
	localparam int OFF_W    = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(FIFO_DEPTH);

	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [BANK_W-1:0] rsel_q;

	logic [NUM_SLOTS-1:0]  slot_v, slot_acc;
	logic [CODE_W-1:0]     slot_code [NUM_SLOTS];
	logic [OFF_W-1:0]      slot_off  [NUM_SLOTS+1];
	logic [PTR_W-1:0]      slot_addr [NUM_SLOTS];
	logic [CNT_W:0]        room;
	logic [OFF_W-1:0]      n_acc;

	logic              bank_we    [NUM_BANKS];
	logic [ROW_W-1:0]  bank_waddr [NUM_BANKS];
	logic [CODE_W-1:0] bank_wdata [NUM_BANKS];
	logic [CODE_W-1:0] bank_rdata [NUM_BANKS];

	logic pop_fire;

	// order the candidate events: key 0 before key 1, down/up before long/repeat
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			slot_v[2*k]      = ctl.tick && (evt[k].down || evt[k].up);
			slot_code[2*k]   = evt[k].down ? code_down(1'(k)) : code_up(1'(k));
			slot_v[2*k+1]    = ctl.tick && (evt[k].long_press || evt[k].rpt);
			slot_code[2*k+1] = evt[k].long_press ? code_long(1'(k)) : code_down(1'(k));
		end
	end

	// merge: prefix offsets, room check, accept flags
	always_comb begin
		room        = DEPTH_C - {1'b0, fill_q};
		slot_off[0] = '0;
		n_acc       = '0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			slot_off[j+1] = slot_off[j] + OFF_W'(slot_v[j]);
			slot_acc[j]   = slot_v[j] && ((CNT_W + 1)'(slot_off[j]) < room);
			slot_addr[j]  = wptr_q + PTR_W'(slot_off[j]);
			n_acc         = n_acc + OFF_W'(slot_acc[j]);
		end
	end

	// route each accepted event to its bank
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			bank_we[b]    = 1'b0;
			bank_waddr[b] = '0;
			bank_wdata[b] = CODE_NONE;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				if (slot_acc[j] && (slot_addr[j][BANK_W-1:0] == BANK_W'(b))) begin
					bank_we[b]    = 1'b1;
					bank_waddr[b] = slot_addr[j][PTR_W-1:BANK_W];
					bank_wdata[b] = slot_code[j];
				end
			end
		end
	end

	assign pop_fire    = ctl.pop && (fill_q != '0);
	assign sts.popped  = pop_fire;
	assign sts.dropped = |(slot_v & ~slot_acc);

	// banks, all read at the row of the read pointer
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		kdf_ram #(
			.WIDTH (CODE_W),
			.DEPTH (ROWS)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr[b]),
			.wdata (bank_wdata[b]),
			.re    (pop_fire),
			.raddr (rptr_q[PTR_W-1:BANK_W]),
			.rdata (bank_rdata[b])
		);
	end

	assign pop_code = bank_rdata[rsel_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
			rsel_q <= '0;
		end else begin
			if (ctl.tick) begin
				wptr_q <= wptr_q + PTR_W'(n_acc);
				fill_q <= fill_q + CNT_W'(n_acc);
			end else if (pop_fire) begin
				rptr_q <= rptr_q + PTR_W'(1);
				fill_q <= fill_q - CNT_W'(1);
				rsel_q <= rptr_q[BANK_W-1:0];
			end else if (ctl.clear) begin
				rptr_q <= wptr_q;
				fill_q <= '0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} <= DEPTH_C)
		else $error("event FIFO fill count above depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear && !ctl.tick && !ctl.pop |=> (fill_q == '0) && (rptr_q == wptr_q))
		else $error("clear did not empty the event FIFO");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !ctl.tick |=> fill_q == $past(fill_q) - CNT_W'(1))
		else $error("pop did not take exactly one word");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		sts.dropped |-> (fill_q + CNT_W'(n_acc)) == CNT_W'(FIFO_DEPTH))
		else $error("event dropped while the FIFO had room");
endmodule

@@ hdl/key_debounce_event_fifo.sv @@
// key_debounce_event_fifo: top level; register file, key lanes, event FIFO, output stages.
// Depends on kdf_pkg, the kdf_*_if interfaces, kdf_key_lane and kdf_event_fifo.

// Two-key scanner with debounce, long press, auto-repeat and a FIFO of key codes.
// Every item (scan tick, read, clear) gives exactly one result word. Both keys are
// updated by their own lane in the accept cycle; events go to a FIFO of FIFO_DEPTH
// codes built from four interleaved banks, so the up to four events of one tick
// are stored in the accept cycle. The block takes one item per clock while req.ready
// is high; a result passes one register stage for the bank read, then one output
// register, before rsp.valid rises, and with the output stalled two results are
// buffered before req.ready drops. An event that finds the FIFO full is lost and
// flags event_dropped. No clearing pass after reset. Registers are written at
// cfg.index 0..4 (filter, long time key 0/1, repeat speed key 0/1); the user must
// write them only while the block is idle, which the block itself does not enforce.

module key_debounce_event_fifo #(
	parameter int FIFO_DEPTH = kdf_pkg::FIFO_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	kdf_req_if.sink   req,
	kdf_rsp_if.source rsp,
	kdf_cfg_if.sink   cfg
);
	import kdf_pkg::*;

	// configuration registers
	logic [FILT_W-1:0] filter_time_q;
	logic [HOLD_W-1:0] long_time_q    [NUM_KEYS];
	logic [RPT_W-1:0]  repeat_speed_q [NUM_KEYS];
	logic              cfg_fire;
	logic [NUM_KEYS-1:0] rpt_clr;

	// item flow
	logic      in_fire, s1_move;
	fifo_ctl_t ctl;
	fifo_sts_t sts;
	key_evt_t  evt [NUM_KEYS];
	logic [NUM_KEYS-1:0] pressed_nxt;
	logic [CODE_W-1:0]   pop_code;

	logic                v_s1, popped_s1, drop_s1;
	logic [NUM_KEYS-1:0] state_s1;
	logic                v_q, drop_q;
	logic [CODE_W-1:0]   code_q;
	logic [NUM_KEYS-1:0] state_q;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_time_q <= FILTER_RST;
			for (int k = 0; k < NUM_KEYS; k++) begin
				long_time_q[k]    <= LONG_RST;
				repeat_speed_q[k] <= RPT_RST;
			end
		end else if (cfg_fire) begin
			unique case (cfg.index)
				CFG_FILTER: filter_time_q     <= cfg.data[FILT_W-1:0];
				CFG_LONG0:  long_time_q[0]    <= cfg.data[HOLD_W-1:0];
				CFG_LONG1:  long_time_q[1]    <= cfg.data[HOLD_W-1:0];
				CFG_RPT0:   repeat_speed_q[0] <= cfg.data[RPT_W-1:0];
				CFG_RPT1:   repeat_speed_q[1] <= cfg.data[RPT_W-1:0];
				default: ;
			endcase
		end
	end

	// a write of a key's long time or repeat speed restarts its repeat count
	assign rpt_clr[0] = cfg_fire && ((cfg.index == CFG_LONG0) || (cfg.index == CFG_RPT0));
	assign rpt_clr[1] = cfg_fire && ((cfg.index == CFG_LONG1) || (cfg.index == CFG_RPT1));

	// handshake and item decode
	assign s1_move   = v_s1 && (!v_q || rsp.ready);
	assign req.ready = !v_s1 || s1_move;
	assign in_fire   = req.valid && req.ready;

	assign ctl.tick  = in_fire && (req.action == ACT_TICK);
	assign ctl.pop   = in_fire && (req.action == ACT_READ);
	assign ctl.clear = in_fire && (req.action == ACT_CLEAR);

	// one lane per key
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kdf_key_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.tick         (ctl.tick),
			.raw_down     (req.key_down[k]),
			.filter_time  (filter_time_q),
			.long_time    (long_time_q[k]),
			.repeat_speed (repeat_speed_q[k]),
			.rpt_clr      (rpt_clr[k]),
			.evt          (evt[k]),
			.pressed_nxt  (pressed_nxt[k])
		);
	end

	kdf_event_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.evt      (evt),
		.sts      (sts),
		.pop_code (pop_code)
	);

	// stage 1: bank read in flight, item status captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			popped_s1 <= sts.popped;
			drop_s1   <= sts.dropped;
			state_s1  <= pressed_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (s1_move) begin
			v_q <= 1'b1;
		end else if (rsp.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			code_q  <= popped_s1 ? pop_code : CODE_NONE;
			state_q <= state_s1;
			drop_q  <= drop_s1;
		end
	end

	assign rsp.valid         = v_q;
	assign rsp.key_code      = code_q;
	assign rsp.key_state     = state_q;
	assign rsp.event_dropped = drop_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> v_s1 && v_q && !rsp.ready)
		else $error("input stalled with a free result stage");

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_move |=> v_s1)
		else $error("stage 1 word lost while output stalled");

	a_drop_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.event_dropped |-> rsp.key_code == CODE_NONE)
		else $error("drop flag set on a read result");
endmodule
